@@ rtl/core/qcw_pkg.sv @@
`timescale 1ns / 1ps
package qcw_pkg;

  localparam logic [1:0] CLS_FINITE = 2'd0;
  localparam logic [1:0] CLS_NAN    = 2'd1;
  localparam logic [1:0] CLS_PINF   = 2'd2;
  localparam logic [1:0] CLS_NINF   = 2'd3;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [0:0] REG_Q_LOW  = 1'b0;
  localparam logic [0:0] REG_Q_HIGH = 1'b1;

  typedef struct packed {
    logic signed [31:0] in_value;
    logic [1:0]         in_class;
    logic               in_last;
  } qcw_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         out_class;
    logic               bounds_found;
    logic               out_last;
  } qcw_out_t;

endpackage

@@ rtl/core/quantile_clip_winsorizer.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Beat
// in      | input     | in_valid/in_ready | qcw_in_t: value, class, last
// out     | output    | out_valid/out_ready | qcw_out_t: value, class, found, last
// cfg     | input     | cfg_we            | cfg_index selects q_low / q_high
//
// Load: a non-NaN beat holds in_ready low after it is taken while it is inserted,
//   each sorted entry shifted taking a read, then a compare and write,
//   with up to MAX_LEN - 1 entries shifted; a NaN beat that does not close frees the port at once.
// Close: two quantiles, each in turn: position, read two entries, two multiplies, sum.
// Emit: each result beat takes a read, a load and a handshake, and waits on output stalls;
//   no input taken meanwhile.
// Reset (rst, synchronous) clears counts and bounds, sets q_low to 0 and q_high to ONE_Q16; memories none.
module quantile_clip_winsorizer
  import qcw_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  qcw_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output qcw_out_t     out_data,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_INS   = 11'b00000000010,  // read sorted[i-1]
    S_CMP   = 11'b00000000100,  // compare, shift or place
    S_QSET  = 11'b00000001000,  // choose quantile position
    S_QRDA  = 11'b00000010000,
    S_QRDB  = 11'b00000100000,
    S_QMUL1 = 11'b00001000000,
    S_QMUL2 = 11'b00010000000,
    S_QSUM  = 11'b00100000000,
    S_ERD   = 11'b01000000000,
    S_EOUT  = 11'b10000000000
  } state_t;

  state_t state;

  logic signed [31:0] elem_mem [MAX_LEN];
  logic [1:0]         cls_mem  [MAX_LEN];
  logic signed [31:0] sort_mem [MAX_LEN];

  logic [16:0] q_low, q_high;
  logic [CW-1:0] elem_cnt, valid_cnt, pos_i, emit_k;
  logic signed [31:0] ins_val, lower_bound, upper_bound, rd_sort, sa, qres;
  logic signed [31:0] elem_rd;
  logic [1:0]  cls_rd;
  logic        in_last_r, q_sel, found;
  logic [16:0] frac;
  logic signed [49:0] prod;     // shared multiplier result
  logic signed [49:0] acc;

  logic [AW-1:0] sort_raddr;
  logic [AW-1:0] elem_raddr;

  // shared multiplier: 17-bit unsigned weight times 32-bit signed value
  logic [16:0]        mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] mul_p;
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // quantile position (n-1)*q, 7 x 17 bits
  logic [16:0] q_cur;
  logic [23:0] qpos;
  logic [6:0]  qidx;
  assign q_cur = q_sel ? q_high : q_low;
  assign qpos  = 24'(valid_cnt - 1'b1) * 24'(q_cur);
  assign qidx  = qpos[22:16];

  // weighted sum, then /65536 truncated toward zero
  logic signed [49:0] qsum, qsum_adj;
  assign qsum     = acc + prod;
  assign qsum_adj = qsum + (qsum[49] ? 50'sd65535 : 50'sd0);
  assign qres     = 32'(qsum_adj >>> 16);

  assign in_ready = (state == S_IDLE);
  logic in_fire;
  assign in_fire = in_valid && in_ready;

  logic [31:0] ins_key;
  always_comb begin
    case (in_data.in_class)
      CLS_PINF: ins_key = 32'h7FFF_FFFF;
      CLS_NINF: ins_key = 32'h8000_0000;
      default:  ins_key = in_data.in_value;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (in_fire && elem_cnt < CW'(MAX_LEN)) begin
      elem_mem[elem_cnt[AW-1:0]] <= in_data.in_value;
      cls_mem[elem_cnt[AW-1:0]]  <= in_data.in_class;
    end
    elem_rd <= elem_mem[elem_raddr];
    cls_rd  <= cls_mem[elem_raddr];
  end

  logic sort_we;
  logic [AW-1:0] sort_waddr;
  logic signed [31:0] sort_wdata;
  always_ff @(posedge clk) begin
    if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
    rd_sort <= sort_mem[sort_raddr];
  end

  assign elem_raddr = emit_k[AW-1:0];

  always_comb begin
    sort_we    = 1'b0;
    sort_waddr = pos_i[AW-1:0];
    sort_wdata = ins_val;
    sort_raddr = AW'(pos_i - 1'b1);
    if (state == S_CMP) begin
      if (pos_i != '0 && rd_sort > ins_val) begin
        sort_we    = 1'b1;
        sort_wdata = rd_sort;
      end else begin
        sort_we = 1'b1;
      end
    end
    if (state == S_QSET || state == S_QRDA || state == S_QRDB || state == S_QMUL1)
      sort_raddr = pos_i[AW-1:0];
  end

  always_comb begin
    mul_a = ONE_Q16 - frac;
    mul_b = sa;
    if (state == S_QMUL2) begin
      mul_a = frac;
      mul_b = rd_sort;
    end
  end

  logic signed [31:0] clip_v;
  always_comb begin
    clip_v = elem_rd;
    if (found && cls_rd == CLS_FINITE) begin
      if (clip_v < lower_bound) clip_v = lower_bound;
      if (clip_v > upper_bound) clip_v = upper_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      q_low       <= '0;
      q_high      <= ONE_Q16;
      elem_cnt    <= '0;
      valid_cnt   <= '0;
      lower_bound <= '0;
      upper_bound <= '0;
      out_valid   <= 1'b0;
      found       <= 1'b0;
      emit_k      <= '0;
      pos_i       <= '0;
      q_sel       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_Q_LOW) q_low <= cfg_data;
        else q_high <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            in_last_r <= in_data.in_last;
            ins_val   <= ins_key;
            pos_i     <= valid_cnt;
            if (elem_cnt < CW'(MAX_LEN)) elem_cnt <= elem_cnt + 1'b1;
            if (elem_cnt < CW'(MAX_LEN) && in_data.in_class != CLS_NAN)
              state <= S_INS;
            else if (in_data.in_last || elem_cnt == CW'(MAX_LEN - 1)) begin
              found <= valid_cnt != '0;
              q_sel <= 1'b0;
              state <= (valid_cnt != '0) ? S_QSET : S_ERD;
              emit_k <= '0;
            end
          end
        end
        S_INS: state <= S_CMP;
        S_CMP: begin
          if (pos_i != '0 && rd_sort > ins_val) begin
            pos_i <= pos_i - 1'b1;
            state <= S_INS;
          end else begin
            valid_cnt <= valid_cnt + 1'b1;
            emit_k <= '0;
            q_sel  <= 1'b0;
            if (in_last_r || elem_cnt == CW'(MAX_LEN)) begin
              found <= 1'b1;
              state <= S_QSET;
            end else state <= S_IDLE;
          end
        end
        S_QSET: begin
          if (q_cur == '0) begin
            pos_i <= '0;
            frac  <= '0;
          end else if (q_cur >= ONE_Q16 || CW'(qidx) + 1'b1 >= valid_cnt) begin
            pos_i <= valid_cnt - 1'b1;
            frac  <= '0;
          end else begin
            pos_i <= CW'(qidx);
            frac  <= {1'b0, qpos[15:0]};
          end
          state <= S_QRDA;
        end
        S_QRDA: begin
          pos_i <= pos_i + (frac != '0 ? 1'b1 : 1'b0);
          state <= S_QRDB;
        end
        S_QRDB: begin
          sa    <= rd_sort;
          state <= S_QMUL1;
        end
        S_QMUL1: begin
          acc   <= mul_p;
          state <= S_QMUL2;
        end
        S_QMUL2: begin
          prod  <= mul_p;
          state <= S_QSUM;
        end
        S_QSUM: begin
          if (!q_sel) begin
            lower_bound <= qres;
            q_sel <= 1'b1;
            state <= S_QSET;
          end else begin
            if (lower_bound > qres) begin
              upper_bound <= lower_bound;
              lower_bound <= qres;
            end else upper_bound <= qres;
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_valid) begin
            out_data.out_value    <= clip_v;
            out_data.out_class    <= cls_rd;
            out_data.bounds_found <= found;
            out_data.out_last     <= (emit_k + 1'b1 == elem_cnt);
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (emit_k + 1'b1 == elem_cnt) begin
              elem_cnt  <= '0;
              valid_cnt <= '0;
              state     <= S_IDLE;
            end else begin
              emit_k <= emit_k + 1'b1;
              state  <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("output while accepting input");
  assert property (@(posedge clk) disable iff (rst) valid_cnt <= elem_cnt)
    else $error("sorted count exceeds element count");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT && out_valid && out_ready && out_data.out_last) |=> state == S_IDLE)
    else $error("vector end not returning idle");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> out_data.bounds_found)
    else $error("found flag lost");

endmodule
